>>> hdl/discovery_response_parser_unit_defines.svh
// ---------------------------------------------------------------------------
// discovery response parser assertion macros
// concurrent check helpers, empty when built for synthesis
// ---------------------------------------------------------------------------
`ifndef DISCOVERY_RESPONSE_PARSER_UNIT_DEFINES_SVH
`define DISCOVERY_RESPONSE_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DRP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DRP_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/drp_pkg.sv
// ---------------------------------------------------------------------------
// drp_pkg
// shared types and codes of the discovery response parser
// ---------------------------------------------------------------------------
`default_nettype none

package drp_pkg;

  // result kinds
  localparam logic [1:0] KIND_STRING = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // string ids
  localparam logic [1:0] STR_IPV6    = 2'd0;
  localparam logic [1:0] STR_HOST    = 2'd1;
  localparam logic [1:0] STR_SERVICE = 2'd2;

  // error codes
  localparam logic [2:0] ERR_SHORT     = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE = 3'd1;
  localparam logic [2:0] ERR_OVERRUN   = 3'd2;
  localparam logic [2:0] ERR_TYPE      = 3'd3;
  localparam logic [2:0] ERR_MARKER    = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  // header layout
  localparam logic [15:0] MIN_LENGTH    = 16'd8;
  localparam logic [16:0] HEADER_LENGTH = 17'd8;
  localparam logic [15:0] SIG_LAST_POS  = 16'd5;
  localparam logic [7:0]  SECTION_MARK  = 8'h53; // 'S'

  // one input word
  typedef struct packed {
    logic        first_byte;
    logic [15:0] datagram_length;
    logic [7:0]  data_byte;
  } item_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  string_id;
    logic [7:0]  string_byte;
    logic [31:0] ipv4_address;
    logic [15:0] service_port;
    logic [7:0]  protocol_code;
    logic [2:0]  error_code;
    logic        message_done;
  } result_t;

  // signature character at a header position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h4E; // N
      3'd1: ch = 8'h59; // Y
      3'd2: ch = 8'h41; // A
      3'd3: ch = 8'h4E; // N
      3'd4: ch = 8'h53; // S
      3'd5: ch = 8'h44; // D
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> hdl/drp_parse.sv
// ---------------------------------------------------------------------------
// drp_parse
// parse state machine: one byte in, at most one result out per step
// ---------------------------------------------------------------------------
`default_nettype none

module drp_parse (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire drp_pkg::item_t  item,
  input  wire logic [7:0]      type_code,
  output drp_pkg::result_t     res,
  output logic                 res_valid
);

  // parse phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SIG     = 4'd1;
  localparam logic [3:0] PH_LEN     = 4'd2;
  localparam logic [3:0] PH_TYPE    = 4'd3;
  localparam logic [3:0] PH_COUNT   = 4'd4;
  localparam logic [3:0] PH_MARKER  = 4'd5;
  localparam logic [3:0] PH_IPV4    = 4'd6;
  localparam logic [3:0] PH_V6LEN   = 4'd7;
  localparam logic [3:0] PH_V6STR   = 4'd8;
  localparam logic [3:0] PH_HOSTLEN = 4'd9;
  localparam logic [3:0] PH_HOSTSTR = 4'd10;
  localparam logic [3:0] PH_PORT    = 4'd11;
  localparam logic [3:0] PH_PROT    = 4'd12;
  localparam logic [3:0] PH_NAMELEN = 4'd13;
  localparam logic [3:0] PH_NAMESTR = 4'd14;
  localparam logic [3:0] PH_DONE    = 4'd15;

  logic [3:0]  phase, phase_next;
  logic [15:0] pos, pos_next;
  logic [15:0] fcnt, fcnt_next;
  logic [15:0] blen, blen_next;
  logic [7:0]  svc, svc_next;
  logic [31:0] addr, addr_next;
  logic [15:0] port, port_next;
  logic [7:0]  prot, prot_next;

  // state as seen by this byte, restarted on a first byte
  logic [3:0]  ph_c;
  logic [15:0] pos_c, fcnt_c, blen_c, port_c;
  logic [7:0]  svc_c, prot_c;
  logic [31:0] addr_c;

  logic [7:0]  b;
  logic [15:0] dl;
  logic        too_short, last, err, emit;
  logic [2:0]  ecode;
  logic [1:0]  kind, sid;
  logic        done;
  logic [15:0] len_full;

  assign b  = item.data_byte;
  assign dl = item.datagram_length;

  // restart view
  always_comb begin
    ph_c   = item.first_byte ? PH_SIG : phase;
    pos_c  = item.first_byte ? 16'd0 : pos;
    fcnt_c = item.first_byte ? 16'd0 : fcnt;
    blen_c = item.first_byte ? 16'd0 : blen;
    svc_c  = item.first_byte ? 8'd0 : svc;
    addr_c = item.first_byte ? 32'd0 : addr;
    port_c = item.first_byte ? 16'd0 : port;
    prot_c = item.first_byte ? 8'd0 : prot;
  end

  assign too_short = item.first_byte && (dl < drp_pkg::MIN_LENGTH);
  assign last      = ({1'b0, pos_c} + 17'd1) >= {1'b0, dl};
  assign len_full  = {b, blen_c[7:0]};

  // byte parse
  always_comb begin
    phase_next = ph_c;
    pos_next   = pos_c;
    fcnt_next  = fcnt_c;
    blen_next  = blen_c;
    svc_next   = svc_c;
    addr_next  = addr_c;
    port_next  = port_c;
    prot_next  = prot_c;
    err   = 1'b0;
    ecode = drp_pkg::ERR_SHORT;
    emit  = 1'b0;
    kind  = drp_pkg::KIND_STRING;
    sid   = drp_pkg::STR_IPV6;
    done  = 1'b0;
    res   = '0;
    res_valid = 1'b0;

    if (too_short) begin
      phase_next     = PH_DONE;
      res_valid      = 1'b1;
      res.kind       = drp_pkg::KIND_ERROR;
      res.error_code = drp_pkg::ERR_SHORT;
    end else if (ph_c != PH_IDLE && ph_c != PH_DONE) begin
      pos_next = pos_c + 16'd1;
      case (ph_c)
        PH_SIG: begin
          if (b != drp_pkg::sig_byte(pos_c[2:0])) begin
            err = 1'b1; ecode = drp_pkg::ERR_SIGNATURE;
          end else if (pos_c >= drp_pkg::SIG_LAST_POS) begin
            phase_next = PH_LEN;
            fcnt_next  = 16'd0;
          end
        end
        PH_LEN: begin
          if (fcnt_c == 16'd0) begin
            blen_next = {8'd0, b};
            fcnt_next = 16'd1;
          end else begin
            blen_next = len_full;
            if (({1'b0, len_full} + drp_pkg::HEADER_LENGTH) > {1'b0, dl}) begin
              err = 1'b1; ecode = drp_pkg::ERR_OVERRUN;
            end else begin
              phase_next = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          if (b != type_code) begin
            err = 1'b1; ecode = drp_pkg::ERR_TYPE;
          end else begin
            phase_next = PH_COUNT;
          end
        end
        PH_COUNT: begin
          svc_next = b;
          if (b == 8'd0) begin
            emit = 1'b1; kind = drp_pkg::KIND_EMPTY; done = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_MARKER;
          end
        end
        PH_MARKER: begin
          if (b != drp_pkg::SECTION_MARK) begin
            err = 1'b1; ecode = drp_pkg::ERR_MARKER;
          end else begin
            phase_next = PH_IPV4;
            fcnt_next  = 16'd0;
            addr_next  = 32'd0;
            port_next  = 16'd0;
            prot_next  = 8'd0;
          end
        end
        PH_IPV4: begin
          addr_next = addr_c | ({24'd0, b} << {fcnt_c[1:0], 3'b000});
          fcnt_next = fcnt_c + 16'd1;
          if (fcnt_c >= 16'd3) phase_next = PH_V6LEN;
        end
        PH_V6LEN: begin
          fcnt_next  = {8'd0, b};
          phase_next = (b == 8'd0) ? PH_HOSTLEN : PH_V6STR;
        end
        PH_V6STR: begin
          emit = 1'b1; kind = drp_pkg::KIND_STRING; sid = drp_pkg::STR_IPV6;
          fcnt_next = fcnt_c - 16'd1;
          if (fcnt_c == 16'd1) phase_next = PH_HOSTLEN;
        end
        PH_HOSTLEN, PH_NAMELEN: begin
          if (fcnt_c == 16'd0) begin
            blen_next = {8'd0, b};
            fcnt_next = 16'd1;
          end else begin
            blen_next = len_full;
            fcnt_next = len_full;
            if (ph_c == PH_HOSTLEN) begin
              phase_next = (len_full == 16'd0) ? PH_PORT : PH_HOSTSTR;
            end else begin
              svc_next = svc_c - 8'd1;
              emit = 1'b1; kind = drp_pkg::KIND_RECORD;
              done = (svc_c == 8'd1);
              if (len_full == 16'd0)
                phase_next = (svc_c == 8'd1) ? PH_DONE : PH_MARKER;
              else
                phase_next = PH_NAMESTR;
            end
          end
        end
        PH_HOSTSTR: begin
          emit = 1'b1; kind = drp_pkg::KIND_STRING; sid = drp_pkg::STR_HOST;
          fcnt_next = fcnt_c - 16'd1;
          if (fcnt_c == 16'd1) phase_next = PH_PORT;
        end
        PH_PORT: begin
          port_next = port_c | ({8'd0, b} << {fcnt_c[0], 3'b000});
          fcnt_next = fcnt_c + 16'd1;
          if (fcnt_c >= 16'd1) phase_next = PH_PROT;
        end
        PH_PROT: begin
          prot_next  = b;
          fcnt_next  = 16'd0;
          phase_next = PH_NAMELEN;
        end
        PH_NAMESTR: begin
          emit = 1'b1; kind = drp_pkg::KIND_STRING; sid = drp_pkg::STR_SERVICE;
          fcnt_next = fcnt_c - 16'd1;
          if (fcnt_c == 16'd1)
            phase_next = (svc_c == 8'd0) ? PH_DONE : PH_MARKER;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase

      // error, truncation, or the normal result
      if (err) begin
        phase_next     = PH_DONE;
        res_valid      = 1'b1;
        res.kind       = drp_pkg::KIND_ERROR;
        res.error_code = ecode;
      end else if (last && phase_next != PH_DONE) begin
        phase_next     = PH_DONE;
        res_valid      = 1'b1;
        res.kind       = drp_pkg::KIND_ERROR;
        res.error_code = drp_pkg::ERR_TRUNCATED;
      end else if (emit) begin
        if (last) phase_next = PH_DONE;
        res_valid        = 1'b1;
        res.kind         = kind;
        res.message_done = done;
        if (kind == drp_pkg::KIND_STRING) begin
          res.string_id   = sid;
          res.string_byte = b;
        end
        if (kind == drp_pkg::KIND_RECORD) begin
          res.ipv4_address  = addr_c;
          res.service_port  = port_c;
          res.protocol_code = prot_c;
        end
      end else if (last) begin
        phase_next = PH_DONE;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos   <= '0;
      fcnt  <= '0;
      blen  <= '0;
      svc   <= '0;
      addr  <= '0;
      port  <= '0;
      prot  <= '0;
    end else if (step) begin
      phase <= phase_next;
      pos   <= pos_next;
      fcnt  <= fcnt_next;
      blen  <= blen_next;
      svc   <= svc_next;
      addr  <= addr_next;
      port  <= port_next;
      prot  <= prot_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/discovery_response_parser_unit.sv
// ---------------------------------------------------------------------------
// discovery_response_parser_unit
// byte stream parser for service-discovery response datagrams
// ---------------------------------------------------------------------------
// Takes one datagram byte per cycle and can keep that pace indefinitely while
// the result side keeps up. Each byte is registered on input, advances the
// parse state machine from the input register and, when it gives a string
// byte, a service record, an empty-message event or an error, lands in the
// output register. The output register holds a stalled result while the
// input register still takes a byte that gives no result; a byte that does
// give one waits in the input register until the output register frees.
// first_byte (s_tuser) restarts the parse.
`default_nettype none
`include "discovery_response_parser_unit_defines.svh"

module discovery_response_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: response type code
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  // input words
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // data_byte[7:0], datagram_length[23:8]
  input  wire logic        s_tuser,   // first_byte
  // result words
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // string_id[1:0], string_byte[9:2],
                                      // ipv4_address[41:10], service_port[57:42],
                                      // protocol_code[65:58], error_code[68:66],
                                      // zero fill[71:69]
  output logic [1:0]       m_tuser,   // kind
  output logic             m_tlast    // message_done
);

  logic [7:0]        type_code;
  logic              s1_valid;
  drp_pkg::item_t    s1_item;
  drp_pkg::result_t  s1_res;
  logic              s1_has;
  logic              s1_go;
  logic              out_free;

  // response type register
  always_ff @(posedge clk) begin
    if (rst) begin
      type_code <= 8'd1;
    end else if (cfg_we) begin
      type_code <= cfg_wdata;
    end
  end

  // input register
  assign out_free = !m_tvalid || m_tready;
  assign s1_go    = s1_valid && (!s1_has || out_free);
  assign s_tready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item <= {s_tuser, s_tdata[23:8], s_tdata[7:0]};
    end
  end

  // parse step
  drp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .item      (s1_item),
    .type_code (type_code),
    .res       (s1_res),
    .res_valid (s1_has)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && s1_has) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_has) begin
      m_tdata <= {3'd0, s1_res.error_code, s1_res.protocol_code, s1_res.service_port,
                  s1_res.ipv4_address, s1_res.string_byte, s1_res.string_id};
      m_tuser <= s1_res.kind;
      m_tlast <= s1_res.message_done;
    end
  end

  // checks
  `DRP_ASSERT_IMPL(a_err_not_done, clk, rst, m_tvalid && m_tuser == drp_pkg::KIND_ERROR, !m_tlast, "error word marked as message end")
  `DRP_ASSERT_IMPL(a_empty_done, clk, rst, m_tvalid && m_tuser == drp_pkg::KIND_EMPTY, m_tlast, "empty message word without message end")
  `DRP_ASSERT_IMPL(a_err_code, clk, rst, m_tvalid && m_tuser == drp_pkg::KIND_ERROR, m_tdata[68:66] != 3'd6 && m_tdata[68:66] != 3'd7, "error code out of range")
  `DRP_ASSERT_IMPL(a_sid_range, clk, rst, m_tvalid && m_tuser == drp_pkg::KIND_STRING, m_tdata[1:0] != 2'd3, "string id out of range")
  `DRP_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_go, s1_valid && $stable(s1_item), "waiting input word lost or changed")

endmodule

`default_nettype wire
